// ===== hdl/pbbe_pkg.sv =====
// ----------------------------------------------------------------------------
// Position bitmap block encoder package
// Shared sizes, codes and types of the position bitmap block encoder.
// ----------------------------------------------------------------------------
package pbbe_pkg;

    localparam int BLOCK_BITS    = 1024;
    localparam int HEADER_WORDS  = 3;
    localparam int BLOCK_WORDS   = (BLOCK_BITS + 31) / 32;
    localparam int PAYLOAD_WORDS = BLOCK_WORDS - HEADER_WORDS;
    localparam int PAYLOAD_BITS  = BLOCK_BITS - 32 * HEADER_WORDS;

    localparam int BC_W = $clog2(PAYLOAD_BITS + 1);
    localparam int WI_W = $clog2(PAYLOAD_WORDS);
    localparam int KW   = $clog2(BLOCK_WORDS);

    typedef logic [BC_W-1:0] bcount_t;
    typedef logic [WI_W-1:0] widx_t;
    typedef logic [KW-1:0]   kidx_t;

    localparam logic [31:0] MARKER_WORD = 32'd1;
    localparam logic [31:0] TOP_BIT     = 32'h8000_0000;

    localparam logic FUNC_POS = 1'b0;
    localparam logic FUNC_END = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MODIFY,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    typedef struct packed {
        logic        clear;
        logic        rd_en;
        widx_t       rd_addr;
        logic        wr_en;
        widx_t       wr_addr;
        logic [31:0] wr_data;
    } store_req_t;

endpackage

// ===== hdl/pbbe_bitmap_store.sv =====
// ----------------------------------------------------------------------------
// Bitmap store
// Payload word memory with a registered read and per-word valid bits.
// ----------------------------------------------------------------------------
module pbbe_bitmap_store
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pbbe_pkg::store_req_t req,
    output logic [31:0]          rd_data
);

    logic [31:0]                          bitmap_mem [0:pbbe_pkg::PAYLOAD_WORDS-1];
    logic [31:0]                          rd_data_reg;
    logic                                 rd_valid_reg;
    logic [pbbe_pkg::PAYLOAD_WORDS-1:0]   valid_reg;
    logic [pbbe_pkg::PAYLOAD_WORDS-1:0]   valid_next;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            bitmap_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= bitmap_mem[req.rd_addr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (req.clear)
        begin
            valid_next = '0;
        end
        if (req.wr_en)
        begin
            valid_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // Words not written since the block opened read as zero.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hdl/position_bitmap_block_encoder.sv =====
// ----------------------------------------------------------------------------
// Position bitmap block encoder
// Packs strictly increasing positions into fixed-size bitmap blocks.
// ----------------------------------------------------------------------------
// A position that extends the open block reads its payload word from the
// bitmap store (ST_IDLE) and then writes it back with the new bit set
// (ST_MODIFY). Opening a block or reporting an out-of-order position needs
// no further state. Emitting a block sends BLOCK_WORDS transfers, each
// through ST_EMIT_RD and then ST_EMIT_WR, as every payload word is read
// from the store before it is sent, so an end item for an open block or an
// overflow holds intake until the last word of the block has been sent.
// A new item is taken only once the output register is empty.
module position_bitmap_block_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // position
    input  logic [0:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // word
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // error
);

    pbbe_pkg::state_t     state_reg, state_next;
    logic                 open_reg, open_next;
    logic                 reopen_reg, reopen_next;
    logic [31:0]          start_reg, start_next;
    logic [31:0]          prev_reg, prev_next;
    logic [31:0]          pend_reg, pend_next;
    pbbe_pkg::bcount_t    bc_reg, bc_next;
    pbbe_pkg::widx_t      widx_reg, widx_next;
    logic [4:0]           bitlo_reg, bitlo_next;
    pbbe_pkg::kidx_t      k_reg, k_next;
    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          out_word_reg, out_word_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_err_reg, out_err_next;

    pbbe_pkg::store_req_t store_req;
    logic [31:0]          store_rd_data;

    logic                 accept;
    logic                 out_free;
    logic [31:0]          diff;
    logic [31:0]          room;
    pbbe_pkg::bcount_t    bc_sum;
    pbbe_pkg::bcount_t    bit_idx;
    logic [31:0]          emit_word;
    pbbe_pkg::kidx_t      k_rel;

    pbbe_bitmap_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (store_rd_data)
    );

    assign s_tready = (state_reg == pbbe_pkg::ST_IDLE) && !out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign diff    = s_tdata - prev_reg;
    assign room    = 32'(pbbe_pkg::PAYLOAD_BITS) - 32'(bc_reg);
    assign bc_sum  = bc_reg + diff[pbbe_pkg::BC_W-1:0];
    assign bit_idx = bc_sum - pbbe_pkg::bcount_t'(1);
    assign k_rel   = k_reg - pbbe_pkg::kidx_t'(pbbe_pkg::HEADER_WORDS);

    always_comb
    begin
        if (k_reg == pbbe_pkg::kidx_t'(0))
        begin
            emit_word = pbbe_pkg::MARKER_WORD;
        end
        else if (k_reg == pbbe_pkg::kidx_t'(1))
        begin
            emit_word = start_reg;
        end
        else if (k_reg == pbbe_pkg::kidx_t'(2))
        begin
            emit_word = 32'(bc_reg);
        end
        else
        begin
            emit_word = store_rd_data;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        open_next      = open_reg;
        reopen_next    = reopen_reg;
        start_next     = start_reg;
        prev_next      = prev_reg;
        pend_next      = pend_reg;
        bc_next        = bc_reg;
        widx_next      = widx_reg;
        bitlo_next     = bitlo_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        store_req      = '0;

        unique case (state_reg)
            pbbe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0] == pbbe_pkg::FUNC_END)
                    begin
                        if (open_reg)
                        begin
                            k_next      = '0;
                            reopen_next = 1'b0;
                            state_next  = pbbe_pkg::ST_EMIT_RD;
                        end
                    end
                    else if (!open_reg)
                    begin
                        store_req.clear   = 1'b1;
                        store_req.wr_en   = 1'b1;
                        store_req.wr_addr = '0;
                        store_req.wr_data = pbbe_pkg::TOP_BIT;
                        start_next        = s_tdata;
                        prev_next         = s_tdata;
                        bc_next           = pbbe_pkg::bcount_t'(1);
                        open_next         = 1'b1;
                    end
                    else if (s_tdata <= prev_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_word_next  = '0;
                        out_last_next  = 1'b1;
                        out_err_next   = 1'b1;
                    end
                    else if (diff <= room)
                    begin
                        bc_next           = bc_sum;
                        prev_next         = s_tdata;
                        widx_next         = pbbe_pkg::widx_t'(bit_idx >> 5);
                        bitlo_next        = bit_idx[4:0];
                        store_req.rd_en   = 1'b1;
                        store_req.rd_addr = pbbe_pkg::widx_t'(bit_idx >> 5);
                        state_next        = pbbe_pkg::ST_MODIFY;
                    end
                    else
                    begin
                        bc_next     = pbbe_pkg::bcount_t'(pbbe_pkg::PAYLOAD_BITS);
                        pend_next   = s_tdata;
                        reopen_next = 1'b1;
                        k_next      = '0;
                        state_next  = pbbe_pkg::ST_EMIT_RD;
                    end
                end
            end

            pbbe_pkg::ST_MODIFY:
            begin
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = widx_reg;
                store_req.wr_data = store_rd_data | (pbbe_pkg::TOP_BIT >> bitlo_reg);
                state_next        = pbbe_pkg::ST_IDLE;
            end

            pbbe_pkg::ST_EMIT_RD:
            begin
                store_req.rd_en   = (k_reg >= pbbe_pkg::kidx_t'(pbbe_pkg::HEADER_WORDS));
                store_req.rd_addr = pbbe_pkg::widx_t'(k_rel);
                state_next        = pbbe_pkg::ST_EMIT_WR;
            end

            pbbe_pkg::ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = emit_word;
                    out_err_next   = 1'b0;
                    out_last_next  = (k_reg == pbbe_pkg::kidx_t'(pbbe_pkg::BLOCK_WORDS - 1));
                    if (k_reg == pbbe_pkg::kidx_t'(pbbe_pkg::BLOCK_WORDS - 1))
                    begin
                        state_next = pbbe_pkg::ST_IDLE;
                        if (reopen_reg)
                        begin
                            store_req.clear   = 1'b1;
                            store_req.wr_en   = 1'b1;
                            store_req.wr_addr = '0;
                            store_req.wr_data = pbbe_pkg::TOP_BIT;
                            start_next        = pend_reg;
                            prev_next         = pend_reg;
                            bc_next           = pbbe_pkg::bcount_t'(1);
                            open_next         = 1'b1;
                        end
                        else
                        begin
                            open_next = 1'b0;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + pbbe_pkg::kidx_t'(1);
                        state_next = pbbe_pkg::ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = pbbe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pbbe_pkg::ST_IDLE;
            open_reg      <= 1'b0;
            reopen_reg    <= 1'b0;
            start_reg     <= '0;
            prev_reg      <= '0;
            bc_reg        <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            reopen_reg    <= reopen_next;
            start_reg     <= start_next;
            prev_reg      <= prev_next;
            bc_reg        <= bc_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        widx_reg     <= widx_next;
        bitlo_reg    <= bitlo_next;
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_word_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_err_reg;

endmodule

// ===== hdl/pbbe_checker.sv =====
// ----------------------------------------------------------------------------
// Position bitmap block encoder checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module pbbe_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic [0:0]  m_tuser
);

    // A stalled result holds until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
        && $stable(m_tuser))
        else $error("stalled result changed");

    // An error result is a single zero word that closes its run.
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 32'd0))
        else $error("malformed error result");

    // Intake is closed while a result waits.
    a_intake_closed: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while result pending");

    // After any final word, of a block or of an error result, the next non-error result is the marker.
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast ##1 (m_tvalid && !m_tuser[0]) [->1]
        |-> m_tdata == 32'd1)
        else $error("block does not start with marker");

endmodule

bind position_bitmap_block_encoder pbbe_checker u_pbbe_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
